// File: rtl/core/efr_pkg.sv
// ----------------------------------------------------------------------------
// efr_pkg
// Shared types and constants of the escaped frame receiver.
// ----------------------------------------------------------------------------
package efr_pkg;

  localparam logic [7:0] SyncByte = 8'hE0;
  localparam logic [7:0] EscByte  = 8'hD0;

  localparam logic [7:0] MaxLengthReset = 8'd102;

  localparam int unsigned CfgIdxW = 1;
  localparam logic [CfgIdxW-1:0] CfgMasterMode = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgMaxLength  = 1'b1;

  localparam logic [1:0] ResOk     = 2'd0;
  localparam logic [1:0] ResLong   = 2'd1;
  localparam logic [1:0] ResBadSum = 2'd2;
  localparam logic [1:0] ResBlank  = 2'd3;

  typedef struct packed {
    logic       is_end;
    logic [7:0] node_id;
    logic [7:0] status_byte;
    logic [7:0] data_byte;
    logic [1:0] frame_result;
  } result_t;

endpackage

// File: rtl/core/efr_decode.sv
// ----------------------------------------------------------------------------
// efr_decode
// Frame state and per-byte decode; produces at most one result per byte.
// ----------------------------------------------------------------------------
module efr_decode (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             accept_i,
  input  logic [7:0]       rx_byte_i,
  input  logic             master_mode_i,
  input  logic [7:0]       max_length_i,
  output logic             res_valid_o,
  output efr_pkg::result_t res_o
);

  localparam logic [2:0] PhHunt   = 3'd0;
  localparam logic [2:0] PhId     = 3'd1;
  localparam logic [2:0] PhLen    = 3'd2;
  localparam logic [2:0] PhStatus = 3'd3;
  localparam logic [2:0] PhData   = 3'd4;
  localparam logic [2:0] PhSum    = 3'd5;

  logic [2:0] phase_q, phase_d;
  logic [7:0] node_q, node_d;
  logic [7:0] status_q, status_d;
  logic [7:0] left_q, left_d;
  logic [7:0] sum_q, sum_d;
  logic       esc_q, esc_d;
  logic       blank_q, blank_d;

  logic [7:0] data_val;
  logic       len_blank;

  assign data_val  = esc_q ? (rx_byte_i + 8'd1) : rx_byte_i;
  assign len_blank = (rx_byte_i <= 8'd1);

  always_comb begin
    phase_d     = phase_q;
    node_d      = node_q;
    status_d    = status_q;
    left_d      = left_q;
    sum_d       = sum_q;
    esc_d       = esc_q;
    blank_d     = blank_q;
    res_valid_o = 1'b0;
    res_o       = '{is_end: 1'b0, node_id: node_q, status_byte: status_q,
                    data_byte: 8'd0, frame_result: efr_pkg::ResOk};
    if (accept_i) begin
      unique case (phase_q)
        PhId: begin
          node_d   = rx_byte_i;
          status_d = 8'd0;
          sum_d    = rx_byte_i;
          esc_d    = 1'b0;
          phase_d  = PhLen;
        end
        PhLen: begin
          sum_d = sum_q + rx_byte_i;
          if (rx_byte_i > max_length_i) begin
            res_valid_o        = 1'b1;
            res_o.is_end       = 1'b1;
            res_o.frame_result = efr_pkg::ResLong;
            phase_d            = PhHunt;
          end else begin
            blank_d = len_blank;
            left_d  = len_blank ? 8'd0 : (rx_byte_i - 8'd1);
            if (master_mode_i) begin
              phase_d = PhStatus;
            end else begin
              phase_d = len_blank ? PhSum : PhData;
            end
          end
        end
        PhStatus: begin
          status_d = rx_byte_i;
          sum_d    = sum_q + rx_byte_i;
          phase_d  = blank_q ? PhSum : PhData;
        end
        PhData: begin
          if (!esc_q && (rx_byte_i == efr_pkg::EscByte)) begin
            esc_d = 1'b1;
          end else begin
            esc_d           = 1'b0;
            sum_d           = sum_q + data_val;
            left_d          = left_q - 8'd1;
            if (left_q == 8'd1) begin
              phase_d = PhSum;
            end
            res_valid_o     = 1'b1;
            res_o.data_byte = data_val;
          end
        end
        PhSum: begin
          phase_d      = PhHunt;
          res_valid_o  = 1'b1;
          res_o.is_end = 1'b1;
          if (rx_byte_i != sum_q) begin
            res_o.frame_result = efr_pkg::ResBadSum;
          end else begin
            res_o.frame_result = blank_q ? efr_pkg::ResBlank : efr_pkg::ResOk;
          end
        end
        default: begin
          phase_d = (rx_byte_i == efr_pkg::SyncByte) ? PhId : PhHunt;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PhHunt;
      node_q   <= 8'd0;
      status_q <= 8'd0;
      left_q   <= 8'd0;
      sum_q    <= 8'd0;
      esc_q    <= 1'b0;
      blank_q  <= 1'b0;
    end else begin
      phase_q  <= phase_d;
      node_q   <= node_d;
      status_q <= status_d;
      left_q   <= left_d;
      sum_q    <= sum_d;
      esc_q    <= esc_d;
      blank_q  <= blank_d;
    end
  end

  a_esc_in_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    esc_q |-> (phase_q == PhData))
    else $error("escape pending outside data phase");

  a_data_left: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PhData) |-> (left_q != 8'd0) && !blank_q)
    else $error("data phase with no bytes left or blank frame");

  a_emit_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> (phase_q == PhLen) || (phase_q == PhData) || (phase_q == PhSum))
    else $error("result from a phase that never emits");

endmodule

// File: rtl/core/efr_obuf.sv
// ----------------------------------------------------------------------------
// efr_obuf
// Result register with a skid entry; decouples input stall from output stall.
// ----------------------------------------------------------------------------
module efr_obuf (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  efr_pkg::result_t push_data_i,
  output logic             full_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output efr_pkg::result_t out_data_o
);

  logic             main_valid_q, main_valid_d;
  logic             skid_valid_q, skid_valid_d;
  efr_pkg::result_t main_q, main_d;
  efr_pkg::result_t skid_q, skid_d;
  logic             pop;

  assign pop = main_valid_q && !out_stall_i;

  always_comb begin
    main_valid_d = main_valid_q;
    skid_valid_d = skid_valid_q;
    main_d       = main_q;
    skid_d       = skid_q;
    if (!main_valid_q || pop) begin
      if (skid_valid_q) begin
        main_d       = skid_q;
        main_valid_d = 1'b1;
        skid_valid_d = 1'b0;
      end else begin
        main_d       = push_data_i;
        main_valid_d = push_i;
      end
    end else if (push_i) begin
      skid_d       = push_data_i;
      skid_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_valid_q <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      main_valid_q <= main_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    main_q <= main_d;
    skid_q <= skid_d;
  end

  assign full_o      = skid_valid_q;
  assign out_valid_o = main_valid_q;
  assign out_data_o  = main_q;

  a_skid_needs_main: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> main_valid_q)
    else $error("skid entry held without a main entry");

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !skid_valid_q)
    else $error("push into a full buffer");

  a_skid_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(skid_valid_q) |-> $past(main_valid_q && out_stall_i))
    else $error("skid filled while output was free");

endmodule

// File: rtl/core/escaped_frame_receiver_top.sv
// ----------------------------------------------------------------------------
// escaped_frame_receiver_top
// Sync-framed byte stream decoder with escape handling and sum check.
// ----------------------------------------------------------------------------
// Takes one received byte per transfer and decodes it combinationally against
// the frame state; a byte can be taken every clock while in_stall_o is low.
// Each data byte and end report is registered in the result register, or
// first in the skid entry while the output stalls. A two-entry output buffer
// (result register plus skid entry) lets input transfers continue while one
// result waits; in_stall_o rises only once both entries are occupied.
// Configuration writes are always ready and take effect on the next byte.
module escaped_frame_receiver_top (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [7:0]                  rx_byte_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic                        is_end_o,
  output logic [7:0]                  node_id_o,
  output logic [7:0]                  status_byte_o,
  output logic [7:0]                  data_byte_o,
  output logic [1:0]                  frame_result_o,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [efr_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [7:0]                  cfg_data_i
);

  logic             master_mode_q;
  logic [7:0]       max_length_q;
  logic             accept;
  logic             res_valid;
  efr_pkg::result_t res;
  efr_pkg::result_t out_data;
  logic             buf_full;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      master_mode_q <= 1'b0;
      max_length_q  <= efr_pkg::MaxLengthReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        efr_pkg::CfgMasterMode: master_mode_q <= cfg_data_i[0];
        efr_pkg::CfgMaxLength:  max_length_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign in_stall_o = buf_full;
  assign accept     = in_valid_i && !buf_full;

  efr_decode u_decode (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .rx_byte_i     (rx_byte_i),
    .master_mode_i (master_mode_q),
    .max_length_i  (max_length_q),
    .res_valid_o   (res_valid),
    .res_o         (res)
  );

  efr_obuf u_obuf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (res_valid),
    .push_data_i (res),
    .full_o      (buf_full),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data)
  );

  assign is_end_o       = out_data.is_end;
  assign node_id_o      = out_data.node_id;
  assign status_byte_o  = out_data.status_byte;
  assign data_byte_o    = out_data.data_byte;
  assign frame_result_o = out_data.frame_result;

endmodule
